FILE: sv/usb_root_hub_request_responder_defines.svh
// ----------------------------------------------------------------------------
// usb_root_hub_request_responder_defines.svh
// assertion macros for the root hub responder, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef USB_ROOT_HUB_REQUEST_RESPONDER_DEFINES_SVH
`define USB_ROOT_HUB_REQUEST_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RHUB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RHUB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RHUB_ASSERT_IMP(lbl, ante, cons, msg)
`define RHUB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/rhub_pkg.sv
// ----------------------------------------------------------------------------
// rhub_pkg
// types, request codes, descriptor tables and microcode for the root hub
// ----------------------------------------------------------------------------
`default_nettype none

package rhub_pkg;

    // request codes as {bRequest, bmRequestType}
    localparam logic [15:0] REQ_GET_STATUS = 16'h0080;
    localparam logic [15:0] REQ_CLEAR_FEAT = 16'h0100;
    localparam logic [15:0] REQ_SET_FEAT   = 16'h0300;
    localparam logic [15:0] REQ_SET_ADDR   = 16'h0500;
    localparam logic [15:0] REQ_GET_DESC   = 16'h0680;
    localparam logic [15:0] REQ_GET_CONF   = 16'h0880;
    localparam logic [15:0] REQ_SET_CONF   = 16'h0900;
    localparam logic [15:0] RCP_IFACE      = 16'h0001;
    localparam logic [15:0] RCP_EP         = 16'h0002;
    localparam logic [15:0] RCP_OTHER      = 16'h0003;
    localparam logic [15:0] TYP_CLASS      = 16'h0020;

    // feature selectors
    localparam logic [15:0] FEAT_ENABLE    = 16'd1;
    localparam logic [15:0] FEAT_SUSPEND   = 16'd2;
    localparam logic [15:0] FEAT_RESET     = 16'd4;
    localparam logic [15:0] FEAT_POWER     = 16'd8;
    localparam logic [15:0] FEAT_C_CONN    = 16'd16;
    localparam logic [15:0] FEAT_C_ENABLE  = 16'd17;
    localparam logic [15:0] FEAT_C_SUSPEND = 16'd18;
    localparam logic [15:0] FEAT_C_OVERCUR = 16'd19;
    localparam logic [15:0] FEAT_C_RESET   = 16'd20;

    // descriptor types
    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;

    // line states
    localparam logic [1:0] LINE_DISCONN = 2'd0;
    localparam logic [1:0] LINE_LOW     = 2'd1;
    localparam logic [1:0] LINE_FULL    = 2'd2;

    // wPortStatus and wPortChange bits
    localparam logic [9:0] ST_CONN = 10'h001;
    localparam logic [9:0] ST_EN   = 10'h002;
    localparam logic [9:0] ST_SUSP = 10'h004;
    localparam logic [9:0] ST_RST  = 10'h010;
    localparam logic [9:0] ST_PWR  = 10'h100;
    localparam logic [9:0] ST_LS   = 10'h200;
    localparam logic [4:0] CH_CONN = 5'h01;
    localparam logic [4:0] CH_EN   = 5'h02;
    localparam logic [4:0] CH_SUSP = 5'h04;
    localparam logic [4:0] CH_OC   = 5'h08;
    localparam logic [4:0] CH_RST  = 5'h10;

    // reply lengths
    localparam logic [4:0] DEV_LEN  = 5'd18;
    localparam logic [4:0] CONF_LEN = 5'd25;
    localparam logic [4:0] HUB_LEN  = 5'd9;
    localparam logic [4:0] LANG_LEN = 5'd4;

    localparam logic [7:0] DEV_DESC [18] = '{
        8'h12, 8'h01, 8'h10, 8'h01, 8'h09, 8'h00, 8'h00, 8'h08, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01
    };
    localparam logic [7:0] CONF_DESC [25] = '{
        8'h09, 8'h02, 8'h19, 8'h00, 8'h01, 8'h01, 8'h00, 8'h40, 8'h00,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h09, 8'h00, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h03, 8'h02, 8'h00, 8'hff
    };
    localparam logic [7:0] HUB_DESC [9] = '{
        8'h09, 8'h29, 8'h01, 8'h00, 8'h00, 8'h50, 8'h00, 8'hfc, 8'hff
    };
    localparam logic [7:0] LANG_DESC [4] = '{8'h04, 8'h03, 8'h00, 8'h00};

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_WORD,
        SRC_DEV,
        SRC_CONF,
        SRC_HUB,
        SRC_LANG
    } src_t;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_DECODE,
        STEP_EMIT
    } step_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_EMIT_DONE
    } cond_t;

    // one control word: strobes, jump condition and jump target
    typedef struct packed {
        logic  in_ready;
        logic  do_decode;
        logic  do_emit;
        cond_t cond;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic in_beat;
        logic emit_done;
    } seq_stat_t;

    // control store
    function automatic ctl_t ucode(input step_t step);
        ctl_t w;
        w = '{in_ready: 1'b0, do_decode: 1'b0, do_emit: 1'b0,
              cond: COND_ALWAYS, target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.in_ready = 1'b1;
                w.cond     = COND_IN_BEAT;
                w.target   = STEP_DECODE;
            end
            STEP_DECODE: begin
                w.do_decode = 1'b1;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.do_emit = 1'b1;
                w.cond    = COND_EMIT_DONE;
                w.target  = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rhub_seq.sv
// ----------------------------------------------------------------------------
// rhub_seq
// step counter and control store; jumps when the step's condition holds
// ----------------------------------------------------------------------------
`default_nettype none

module rhub_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rhub_pkg::seq_stat_t stat,
    output rhub_pkg::ctl_t         ctl
);

    rhub_pkg::step_t step_reg;
    rhub_pkg::step_t step_next;
    logic            jump;

    // outputs
    always_comb begin
        ctl = rhub_pkg::ucode(step_reg);
    end

    // next step
    always_comb begin
        case (ctl.cond)
            rhub_pkg::COND_ALWAYS:    jump = 1'b1;
            rhub_pkg::COND_IN_BEAT:   jump = stat.in_beat;
            rhub_pkg::COND_EMIT_DONE: jump = stat.emit_done;
            default:                  jump = 1'b1;
        endcase
        step_next = jump ? ctl.target : step_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= rhub_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/usb_root_hub_request_responder.sv
// ----------------------------------------------------------------------------
// usb_root_hub_request_responder
// one-port virtual root hub: answers setup requests, tracks port status
//
//   channel   dir   handshake            payload
//   s_        in    s_valid / s_ready    cmd, request, value, length, line
//   m_        out   m_valid / m_ready    one reply byte and its flags
//
// an item passes the sequencer steps idle (takes the beat), decode and emit;
// emit loads the reply beats: n for an n-byte reply (at most 25), one otherwise
// the next item is taken once the last beat of a reply sits in the output
// register; m_ready low holds the sequencer in its emit step
// synchronous active-low reset clears port status, change bits and address
// ----------------------------------------------------------------------------
`default_nettype none

`include "usb_root_hub_request_responder_defines.svh"

module usb_root_hub_request_responder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_request_type,
    input  wire logic [7:0]  s_request_code,
    input  wire logic [15:0] s_feature_value,
    input  wire logic [15:0] s_host_buffer_length,
    input  wire logic [1:0]  s_line_state,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_byte,
    output logic             m_byte_valid,
    output logic             m_last,
    output logic             m_stall_res,
    output logic             m_bus_reset_pulse,
    output logic [6:0]       m_hub_address
);

    rhub_pkg::ctl_t      ctl;
    rhub_pkg::seq_stat_t stat;

    // input beat
    logic        cmd_reg;
    logic [15:0] rq_reg;
    logic [15:0] value_reg;
    logic [15:0] blen_reg;
    logic [1:0]  line_reg;

    // hub state
    logic [9:0] status_reg, status_next;
    logic [4:0] change_reg, change_next;
    logic [6:0] addr_reg, addr_next;

    // reply
    rhub_pkg::src_t src_reg, src_next;
    logic [4:0]     len_reg;
    logic [4:0]     len_next;
    logic [4:0]     eff_len;
    logic           stall_reg, stall_next;
    logic           pulse_reg, pulse_next;
    logic [7:0]     word_reg  [4];
    logic [7:0]     word_next [4];
    logic [4:0]     idx_reg;
    logic [4:0]     idx_inc;
    logic [7:0]     cur_byte;
    logic           cur_valid;
    logic           cur_last;
    logic           load;
    logic           in_beat;

    // output register
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_bvalid_reg;
    logic       m_last_reg;
    logic       m_stall_reg;
    logic       m_pulse_reg;
    logic [6:0] m_addr_reg;

    rhub_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    assign s_ready      = ctl.in_ready;
    assign in_beat      = s_valid && ctl.in_ready;
    assign load         = ctl.do_emit && (!m_valid_reg || m_ready);
    assign idx_inc      = idx_reg + 5'd1;
    assign cur_valid    = !stall_reg && (len_reg != 5'd0);
    assign cur_last     = !cur_valid || (idx_inc == len_reg);
    assign stat.in_beat   = in_beat;
    assign stat.emit_done = load && cur_last;

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            cmd_reg   <= s_cmd;
            rq_reg    <= {s_request_code, s_request_type};
            value_reg <= s_feature_value;
            blen_reg  <= s_host_buffer_length;
            line_reg  <= s_line_state;
        end
    end

    // request decode and state update
    always_comb begin
        status_next = status_reg;
        change_next = change_reg;
        addr_next   = addr_reg;
        src_next    = rhub_pkg::SRC_NONE;
        len_next    = 5'd0;
        stall_next  = 1'b0;
        pulse_next  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            word_next[i] = 8'h00;
        end
        if (cmd_reg) begin
            case (line_reg)
                rhub_pkg::LINE_DISCONN:
                    status_next = status_reg & ~(rhub_pkg::ST_CONN | rhub_pkg::ST_EN);
                rhub_pkg::LINE_LOW:
                    status_next = status_reg | rhub_pkg::ST_CONN | rhub_pkg::ST_LS;
                rhub_pkg::LINE_FULL:
                    status_next = (status_reg | rhub_pkg::ST_CONN) & ~rhub_pkg::ST_LS;
                default: ;
            endcase
            change_next = change_reg | rhub_pkg::CH_CONN;
        end else begin
            case (rq_reg)
                rhub_pkg::REQ_GET_STATUS: begin
                    src_next     = rhub_pkg::SRC_WORD;
                    word_next[0] = 8'h01;
                    len_next     = 5'd2;
                end
                rhub_pkg::REQ_GET_STATUS | rhub_pkg::RCP_IFACE,
                rhub_pkg::REQ_GET_STATUS | rhub_pkg::RCP_EP: begin
                    src_next = rhub_pkg::SRC_WORD;
                    len_next = 5'd2;
                end
                rhub_pkg::REQ_GET_STATUS | rhub_pkg::TYP_CLASS: begin
                    src_next = rhub_pkg::SRC_WORD;
                    len_next = 5'd4;
                end
                rhub_pkg::REQ_GET_STATUS | rhub_pkg::RCP_OTHER | rhub_pkg::TYP_CLASS: begin
                    src_next     = rhub_pkg::SRC_WORD;
                    word_next[0] = status_reg[7:0];
                    word_next[1] = {6'd0, status_reg[9:8]};
                    word_next[2] = {3'd0, change_reg};
                    len_next     = 5'd4;
                end
                rhub_pkg::REQ_CLEAR_FEAT | rhub_pkg::RCP_EP,
                rhub_pkg::REQ_CLEAR_FEAT | rhub_pkg::TYP_CLASS,
                rhub_pkg::REQ_SET_CONF: ;
                rhub_pkg::REQ_CLEAR_FEAT | rhub_pkg::RCP_OTHER | rhub_pkg::TYP_CLASS: begin
                    case (value_reg)
                        rhub_pkg::FEAT_ENABLE:
                            status_next = status_reg & ~rhub_pkg::ST_EN;
                        rhub_pkg::FEAT_SUSPEND:
                            status_next = status_reg & ~rhub_pkg::ST_SUSP;
                        rhub_pkg::FEAT_POWER:
                            status_next = status_reg & ~rhub_pkg::ST_PWR;
                        rhub_pkg::FEAT_C_CONN:
                            change_next = change_reg & ~rhub_pkg::CH_CONN;
                        rhub_pkg::FEAT_C_ENABLE:
                            change_next = change_reg & ~rhub_pkg::CH_EN;
                        rhub_pkg::FEAT_C_SUSPEND:
                            change_next = change_reg & ~rhub_pkg::CH_SUSP;
                        rhub_pkg::FEAT_C_OVERCUR:
                            change_next = change_reg & ~rhub_pkg::CH_OC;
                        rhub_pkg::FEAT_C_RESET:
                            change_next = change_reg & ~rhub_pkg::CH_RST;
                        default: ;
                    endcase
                end
                rhub_pkg::REQ_SET_FEAT | rhub_pkg::RCP_OTHER | rhub_pkg::TYP_CLASS: begin
                    case (value_reg)
                        rhub_pkg::FEAT_SUSPEND:
                            status_next = status_reg | rhub_pkg::ST_SUSP;
                        rhub_pkg::FEAT_RESET: begin
                            pulse_next  = 1'b1;
                            change_next = rhub_pkg::CH_RST;
                            status_next = (status_reg & ~rhub_pkg::ST_RST) | rhub_pkg::ST_EN;
                        end
                        rhub_pkg::FEAT_POWER:
                            status_next = status_reg | rhub_pkg::ST_PWR;
                        rhub_pkg::FEAT_ENABLE:
                            status_next = status_reg | rhub_pkg::ST_EN;
                        default: ;
                    endcase
                end
                rhub_pkg::REQ_SET_ADDR:
                    addr_next = value_reg[6:0];
                rhub_pkg::REQ_GET_DESC: begin
                    case (value_reg[15:8])
                        rhub_pkg::DESC_DEVICE: begin
                            src_next = rhub_pkg::SRC_DEV;
                            len_next = rhub_pkg::DEV_LEN;
                        end
                        rhub_pkg::DESC_CONFIG: begin
                            src_next = rhub_pkg::SRC_CONF;
                            len_next = rhub_pkg::CONF_LEN;
                        end
                        rhub_pkg::DESC_STRING: begin
                            if (value_reg[7:0] == 8'd0) begin
                                src_next = rhub_pkg::SRC_LANG;
                                len_next = rhub_pkg::LANG_LEN;
                            end else begin
                                stall_next = 1'b1;
                            end
                        end
                        default: stall_next = 1'b1;
                    endcase
                end
                rhub_pkg::REQ_GET_DESC | rhub_pkg::TYP_CLASS: begin
                    src_next = rhub_pkg::SRC_HUB;
                    len_next = rhub_pkg::HUB_LEN;
                end
                rhub_pkg::REQ_GET_CONF: begin
                    src_next     = rhub_pkg::SRC_WORD;
                    word_next[0] = 8'h01;
                    len_next     = 5'd1;
                end
                default: stall_next = 1'b1;
            endcase
        end
        // cut to the host buffer
        eff_len = (blen_reg < {11'd0, len_next}) ? blen_reg[4:0] : len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= '0;
            change_reg <= '0;
            addr_reg   <= '0;
        end else if (ctl.do_decode) begin
            status_reg <= status_next;
            change_reg <= change_next;
            addr_reg   <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.do_decode) begin
            src_reg   <= src_next;
            len_reg   <= eff_len;
            stall_reg <= stall_next;
            pulse_reg <= pulse_next;
            word_reg  <= word_next;
            idx_reg   <= 5'd0;
        end else if (load) begin
            idx_reg <= idx_inc;
        end
    end

    // reply byte fetch
    always_comb begin
        case (src_reg)
            rhub_pkg::SRC_WORD: cur_byte = word_reg[idx_reg[1:0]];
            rhub_pkg::SRC_DEV:  cur_byte = rhub_pkg::DEV_DESC[idx_reg];
            rhub_pkg::SRC_CONF: cur_byte = rhub_pkg::CONF_DESC[idx_reg];
            rhub_pkg::SRC_HUB:  cur_byte = rhub_pkg::HUB_DESC[idx_reg[3:0]];
            rhub_pkg::SRC_LANG: cur_byte = rhub_pkg::LANG_DESC[idx_reg[1:0]];
            default:            cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg   <= cur_valid ? cur_byte : 8'h00;
            m_bvalid_reg <= cur_valid;
            m_last_reg   <= cur_last;
            m_stall_reg  <= stall_reg;
            m_pulse_reg  <= pulse_reg && !stall_reg;
            m_addr_reg   <= addr_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_data_byte       = m_data_reg;
    assign m_byte_valid      = m_bvalid_reg;
    assign m_last            = m_last_reg;
    assign m_stall_res       = m_stall_reg;
    assign m_bus_reset_pulse = m_pulse_reg;
    assign m_hub_address     = m_addr_reg;

    `RHUB_ASSERT_IMP(a_stall_beat, m_valid && m_stall_res, !m_byte_valid && m_last && !m_bus_reset_pulse, "stall beat carries data")
    `RHUB_ASSERT_NXT(a_one_item, in_beat, !s_ready, "second beat taken before reply")
    `RHUB_ASSERT_IMP(a_idx_range, ctl.do_emit && cur_valid, idx_reg < len_reg, "reply index past length")
    `RHUB_ASSERT_IMP(a_len_max, ctl.do_emit, len_reg <= rhub_pkg::CONF_LEN, "reply longer than any table")

endmodule

`default_nettype wire
